FILE: rtl/rmv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rmv_pkg
// Types and codes shared by the running mean and variance block.
// ---------------------------------------------------------------------------
package rmv_pkg;

    // item mode codes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // fixed widths of the result words
    localparam int VAR_W  = 64;
    localparam int ROOT_W = 32;

    // input item
    typedef struct packed {
        logic               mode;
        logic signed [31:0] sample;
    } rmv_req_t;

    // result item
    typedef struct packed {
        logic        [31:0] sample_count;
        logic signed [31:0] running_mean;
        logic        [63:0] sample_variance;
        logic        [31:0] std_deviation;
    } rmv_rsp_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MDIV,
        ST_MEAN,
        ST_MUL,
        ST_ACC,
        ST_VSTART,
        ST_VDIV,
        ST_SQRT,
        ST_DONE
    } rmv_state_t;

endpackage : rmv_pkg
`default_nettype wire

FILE: rtl/running_mean_variance.sv
`default_nettype none
// Sequence: a clear or the first sample after a clear goes via ST_VSTART to ST_DONE;
//   other samples pass ST_MDIV, ST_MEAN, ST_MUL, ST_ACC, ST_VDIV and ST_SQRT first.
// Items: one at a time, none taken until ST_DONE; the shared compare/subtract unit runs
//   the mean division (SAMPLE_WIDTH steps), variance division (64) and root (32).
// Reset: rst_n clears count, mean and sum of squares and drops rsp_valid at once.
// ---------------------------------------------------------------------------
// running_mean_variance
// One-pass running count, mean, unbiased variance and standard deviation of
// signed fixed-point samples, with both divisions and the root on one iterative unit.
// ---------------------------------------------------------------------------
module running_mean_variance
    import rmv_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire rmv_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output rmv_rsp_t      rsp
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COUNT_WIDTH;
    localparam int REM_W = (CW + 1 > ROOT_W + 3) ? CW + 1 : ROOT_W + 3;

    // control and statistics state
    rmv_state_t             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic signed [SW-1:0]   mean_reg, mean_next;
    logic [VAR_W-1:0]       ss_reg, ss_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // working registers
    logic signed [SW-1:0]   x_reg, x_next;
    logic [SW-1:0]          dmag_reg, dmag_next;
    logic                   dneg_reg, dneg_next;
    logic [SW-1:0]          m2_reg, m2_next;
    logic [VAR_W-1:0]       prod_reg, prod_next;
    logic [VAR_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]          divisor_reg, divisor_next;
    logic [5:0]             step_reg, step_next;
    logic [VAR_W-1:0]       var_reg, var_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    rmv_rsp_t               rsp_reg, rsp_next;

    // shared compare/subtract unit
    logic [REM_W-1:0]       a_sh;
    logic [REM_W-1:0]       b_op;
    logic [REM_W:0]         diff;
    logic                   ge;

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            a_sh = {rem_reg[REM_W-3:0], quo_reg[VAR_W-1 -: 2]};
            b_op = REM_W'({root_reg, 2'b01});
        end
        else
        begin
            a_sh = {rem_reg[REM_W-2:0], quo_reg[VAR_W-1]};
            b_op = REM_W'(divisor_reg);
        end
        diff = {1'b0, a_sh} - {1'b0, b_op};
        ge   = ~diff[REM_W];
    end

    // incoming sample and its difference from the mean
    logic signed [SW-1:0]   x_in;
    logic [SW:0]            delta_in;
    logic [SW:0]            delta_abs;
    logic [CW-1:0]          count_inc;

    always_comb
    begin
        x_in      = req.sample[SW-1:0];
        delta_in  = {x_in[SW-1], x_in} - {mean_reg[SW-1], mean_reg};
        delta_abs = delta_in[SW] ? (~delta_in + 1'b1) : delta_in;
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    // mean update from the quotient magnitude
    logic [SW:0]            q_signed;
    logic [SW:0]            nm_wide;
    logic [SW-1:0]          new_mean;
    logic [SW:0]            d2;
    logic [SW:0]            d2_abs;
    logic [2*SW-1:0]        prod_full;
    logic [VAR_W:0]         ss_sum;

    always_comb
    begin
        q_signed  = dneg_reg ? (~{1'b0, quo_reg[SW-1:0]} + 1'b1) : {1'b0, quo_reg[SW-1:0]};
        nm_wide   = {mean_reg[SW-1], mean_reg} + q_signed;
        new_mean  = nm_wide[SW-1:0];
        d2        = {x_reg[SW-1], x_reg} - {new_mean[SW-1], new_mean};
        d2_abs    = d2[SW] ? (~d2 + 1'b1) : d2;
        prod_full = dmag_reg * m2_reg;
        ss_sum    = {1'b0, ss_reg} + {1'b0, prod_reg};
    end

    // sequencer: next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        ss_next        = ss_reg;
        rsp_valid_next = rsp_valid_reg;
        x_next         = x_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        m2_next        = m2_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;
        var_next       = var_reg;
        root_next      = root_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                        mean_next  = '0;
                        ss_next    = '0;
                        state_next = ST_VSTART;
                    end
                    else if (count_reg == '0)
                    begin
                        // first sample sets the mean
                        count_next = count_inc;
                        mean_next  = x_in;
                        ss_next    = '0;
                        state_next = ST_VSTART;
                    end
                    else
                    begin
                        count_next   = count_inc;
                        x_next       = x_in;
                        dmag_next    = delta_abs[SW-1:0];
                        dneg_next    = delta_in[SW];
                        quo_next     = {delta_abs[SW-1:0], {(VAR_W-SW){1'b0}}};
                        rem_next     = '0;
                        divisor_next = count_inc;
                        step_next    = 6'(SW - 1);
                        state_next   = ST_MDIV;
                    end
                end
            end

            // delta / count, one quotient bit a cycle
            ST_MDIV:
            begin
                rem_next = ge ? diff[REM_W-1:0] : a_sh;
                quo_next = {quo_reg[VAR_W-2:0], ge};
                if (step_reg == '0)
                begin
                    state_next = ST_MEAN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_MEAN:
            begin
                mean_next  = new_mean;
                m2_next    = d2_abs[SW-1:0];
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = VAR_W'(prod_full);
                state_next = ST_ACC;
            end

            // saturating accumulate of the sum of squares
            ST_ACC:
            begin
                ss_next    = ss_sum[VAR_W] ? '1 : ss_sum[VAR_W-1:0];
                state_next = ST_VSTART;
            end

            ST_VSTART:
            begin
                if (count_reg > CW'(1))
                begin
                    quo_next     = ss_reg;
                    rem_next     = '0;
                    divisor_next = count_reg - 1'b1;
                    step_next    = 6'(VAR_W - 1);
                    state_next   = ST_VDIV;
                end
                else
                begin
                    var_next   = '0;
                    root_next  = '0;
                    state_next = ST_DONE;
                end
            end

            // sum of squares / (count - 1)
            ST_VDIV:
            begin
                rem_next = ge ? diff[REM_W-1:0] : a_sh;
                quo_next = {quo_reg[VAR_W-2:0], ge};
                if (step_reg == '0)
                begin
                    var_next   = {quo_reg[VAR_W-2:0], ge};
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = 6'(ROOT_W - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            // square root, two radicand bits a cycle
            ST_SQRT:
            begin
                rem_next  = ge ? diff[REM_W-1:0] : a_sh;
                root_next = {root_reg[ROOT_W-2:0], ge};
                quo_next  = {quo_reg[VAR_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.sample_count    = 32'(count_reg);
                    rsp_next.running_mean    = (count_reg != '0) ? 32'(mean_reg) : '0;
                    rsp_next.sample_variance = var_reg;
                    rsp_next.std_deviation   = root_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            ss_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            ss_reg        <= ss_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        m2_reg      <= m2_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
        var_reg     <= var_next;
        root_reg    <= root_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    logic req_accept;
    assign req_accept = req_valid && !req_stall;

    a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && req.mode == MODE_CLEAR |=> count_reg == '0)
        else $error("count not cleared");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && req.mode == MODE_PUSH && count_reg != '1
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not advance");

    a_quotient_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MEAN |-> quo_reg[SW-1:0] <= dmag_reg)
        else $error("mean quotient exceeds delta");

    a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> rem_reg <= REM_W'({root_reg, 1'b0}))
        else $error("root remainder out of range");

    a_small_count_no_var: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.sample_count < 32'd2 |-> rsp_reg.sample_variance == '0)
        else $error("variance reported below two samples");

endmodule : running_mean_variance
`default_nettype wire
